/* rtl/neighbour_middle_sum_stencil_macros.svh */
// ---------------------------------------------------------------------------
// neighbour_middle_sum_stencil assertion macros
// shorthand for clocked checks used by the stencil checker
// ---------------------------------------------------------------------------
`ifndef NEIGHBOUR_MIDDLE_SUM_STENCIL_MACROS_SVH
`define NEIGHBOUR_MIDDLE_SUM_STENCIL_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stencil check failed");

// consequent checked in the same cycle as the antecedent
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stencil check failed");

`endif

/* rtl/nmss_pkg.sv */
// ---------------------------------------------------------------------------
// nmss_pkg
// shared widths, register codes and per-item control for the stencil
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmss_pkg;

	localparam int CELL_W    = 15;
	localparam int SUM_W     = 16;
	localparam int DIM_W     = 13;
	localparam int MOD_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int MIN_DIM   = 3;
	localparam int DIM_RESET = 4096;

	localparam logic [MOD_W-1:0] MOD_RESET = 16'd9999;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BOARD_DIM     = 1'b0,
		CFG_VALUE_MODULUS = 1'b1
	} cfg_reg_t;

	// what one accepted cell releases
	typedef struct packed {
		logic has_up;    // cell of the row above is released
		logic has_self;  // last row: the cell itself follows
		logic border;    // released upper cell passes through
		logic last_col;
	} item_ctl_t;

endpackage

/* rtl/nmss_ram.sv */
// ---------------------------------------------------------------------------
// nmss_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmss_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read at the written address returns the old entry
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

/* rtl/nmss_sort.sv */
// ---------------------------------------------------------------------------
// nmss_sort
// compare network picking the two middle values of four neighbours
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmss_sort (
	input  logic [nmss_pkg::CELL_W-1:0] east,
	input  logic [nmss_pkg::CELL_W-1:0] west,
	input  logic [nmss_pkg::CELL_W-1:0] north,
	input  logic [nmss_pkg::CELL_W-1:0] south,
	output logic [nmss_pkg::CELL_W-1:0] upper_min,
	output logic [nmss_pkg::CELL_W-1:0] lower_max
);

	logic [nmss_pkg::CELL_W-1:0] ew_hi, ew_lo, ns_hi, ns_lo;

	always_comb begin
		ew_hi = (east < west) ? west : east;
		ew_lo = (east < west) ? east : west;
		ns_hi = (north < south) ? south : north;
		ns_lo = (north < south) ? north : south;
		upper_min = (ew_hi < ns_hi) ? ew_hi : ns_hi;
		lower_max = (ew_lo < ns_lo) ? ns_lo : ew_lo;
	end

endmodule

/* rtl/nmss_out.sv */
// ---------------------------------------------------------------------------
// nmss_out
// wrapped middle sum and result register, up to two results per item
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmss_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  nmss_pkg::item_ctl_t         ctl,
	input  logic [nmss_pkg::CELL_W-1:0] upper_min,
	input  logic [nmss_pkg::CELL_W-1:0] lower_max,
	input  logic [nmss_pkg::CELL_W-1:0] centre,
	input  logic [nmss_pkg::CELL_W-1:0] own_cell,
	input  logic [nmss_pkg::MOD_W-1:0]  modulus,
	input  logic                        result_stall,
	output logic                        take,
	output logic                        result_valid,
	output logic [nmss_pkg::CELL_W-1:0] new_value,
	output logic                        run_end,
	output logic                        board_end
);

	logic                        up_pend_q, self_pend_q, bend_q;
	logic [nmss_pkg::CELL_W-1:0] up_val_q, self_val_q;
	logic [nmss_pkg::SUM_W-1:0]  sum, wrapped;
	logic [nmss_pkg::CELL_W-1:0] up_val;
	logic                        xfer;

	always_comb begin
		sum     = nmss_pkg::SUM_W'(upper_min) + nmss_pkg::SUM_W'(lower_max);
		wrapped = (sum >= modulus) ? sum - modulus : sum;
		up_val  = ctl.border ? centre : wrapped[nmss_pkg::CELL_W-1:0];
	end

	assign result_valid = up_pend_q || self_pend_q;
	assign new_value    = up_pend_q ? up_val_q : self_val_q;
	assign run_end      = up_pend_q ? !self_pend_q : 1'b1;
	assign board_end    = up_pend_q ? 1'b0 : bend_q;
	assign xfer         = result_valid && !result_stall;
	// free when nothing is held or once the last result of the held item goes out
	assign take = !result_valid || (xfer && !(up_pend_q && self_pend_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_pend_q   <= 1'b0;
			self_pend_q <= 1'b0;
		end else if (load) begin
			up_pend_q   <= ctl.has_up;
			self_pend_q <= ctl.has_self;
		end else if (xfer) begin
			if (up_pend_q) begin
				up_pend_q <= 1'b0;
			end else begin
				self_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			up_val_q   <= up_val;
			self_val_q <= own_cell;
			bend_q     <= ctl.last_col;
		end
	end

endmodule

/* rtl/neighbour_middle_sum_stencil.sv */
// ---------------------------------------------------------------------------
// neighbour_middle_sum_stencil
// raster-order board stencil: middle-two neighbour sum with modulus wrap
// ---------------------------------------------------------------------------
//  channel   signals                               direction
//  cell      cell_valid cell_stall cell_value      in, one board cell
//  result    result_valid result_stall new_value   out, one next-board cell
//            run_end board_end
//  cfg       cfg_valid cfg_ready cfg_index cfg_data in, register write
//
//  one cell per cycle while cell_stall is low; a released result is registered
//  after the line store read, after the compare network and after the wrapped sum
//  last-row cells give two results, so there the result port sets the pace
//  and the result register takes no new cell until the second result goes out
//  reset presets config, clears counters, window and valid flags, not line stores
//  result_stall backs up through the stages to cell_stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbour_middle_sum_stencil #(
	parameter int MAX_DIM = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cell_valid,
	output logic                           cell_stall,
	input  logic [nmss_pkg::CELL_W-1:0]    cell_value,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [nmss_pkg::CELL_W-1:0]    new_value,
	output logic                           run_end,
	output logic                           board_end,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [nmss_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nmss_pkg::CFG_W-1:0]     cfg_data
);

	localparam int AW = $clog2(MAX_DIM);
	localparam int CW = (AW + 1 > nmss_pkg::DIM_W) ? AW + 1 : nmss_pkg::DIM_W;
	localparam logic [AW-1:0] LIM_MAX = AW'(MAX_DIM - 1);
	localparam logic [AW-1:0] LIM_MIN = AW'(nmss_pkg::MIN_DIM - 1);
	localparam logic [AW-1:0] LIM_RST =
		AW'(((MAX_DIM < nmss_pkg::DIM_RESET) ? MAX_DIM : nmss_pkg::DIM_RESET) - 1);

	// configuration, board_dim kept as its clamped last index
	logic [AW-1:0]              lim_q, lim_wr;
	logic [nmss_pkg::MOD_W-1:0] mod_q;
	logic [CW-1:0]              dim_x;

	// position of the next cell
	logic [AW-1:0] col_q, row_q;
	logic [AW-1:0] col0, right_addr;
	logic          last_col0, last_row0;
	nmss_pkg::item_ctl_t ctl0;
	logic          accept;

	// stage 1: line store data arrives
	logic                        v_s1;
	logic [nmss_pkg::CELL_W-1:0] cell_s1;
	logic [AW-1:0]               col_s1;
	nmss_pkg::item_ctl_t         ctl_s1;
	logic [nmss_pkg::CELL_W-1:0] centre_rd, right_rd, up_rd, win_q;
	logic [nmss_pkg::CELL_W-1:0] umin, lmax;
	logic                        s1_adv, s1_free;

	// stage 2: sorted pair
	logic                        v_s2;
	logic [nmss_pkg::CELL_W-1:0] umin_s2, lmax_s2, centre_s2, cell_s2;
	nmss_pkg::item_ctl_t         ctl_s2;
	logic                        s2_ready, out_take, out_load;

	assign cfg_ready = 1'b1;

	always_comb begin
		dim_x = CW'(cfg_data[nmss_pkg::DIM_W-1:0]);
		if (dim_x < CW'(nmss_pkg::MIN_DIM)) begin
			lim_wr = LIM_MIN;
		end else if (dim_x > CW'(MAX_DIM)) begin
			lim_wr = LIM_MAX;
		end else begin
			lim_wr = AW'(dim_x - CW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RST;
			mod_q <= nmss_pkg::MOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (nmss_pkg::cfg_reg_t'(cfg_index))
				nmss_pkg::CFG_BOARD_DIM: begin
					lim_q <= lim_wr;
				end
				nmss_pkg::CFG_VALUE_MODULUS: begin
					mod_q <= cfg_data[nmss_pkg::MOD_W-1:0];
				end
			endcase
		end
	end

	// a count at or past the last index counts as the last one
	always_comb begin
		col0       = (col_q >= lim_q) ? lim_q : col_q;
		last_col0  = (col0 == lim_q);
		last_row0  = (row_q >= lim_q);
		right_addr = last_col0 ? '0 : col0 + AW'(1);
		ctl0.has_up   = (row_q != '0);
		ctl0.has_self = last_row0;
		ctl0.last_col = last_col0;
		ctl0.border   = (row_q == AW'(1)) || (col0 == '0) || last_col0 || (row_q > lim_q);
	end

	assign s2_ready   = !v_s2 || !(ctl_s2.has_up || ctl_s2.has_self) || out_take;
	assign s1_adv     = v_s1 && s2_ready;
	assign s1_free    = !v_s1 || s2_ready;
	assign cell_stall = !s1_free;
	assign accept     = cell_valid && s1_free;
	assign out_load   = v_s2 && (ctl_s2.has_up || ctl_s2.has_self) && out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col0) begin
				col_q <= '0;
				row_q <= last_row0 ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col0 + AW'(1);
			end
		end
	end

	// two copies of the row above so the centre and right cells read together
	nmss_ram #(.WIDTH(nmss_pkg::CELL_W), .DEPTH(MAX_DIM)) u_above_centre (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col0),
		.wr_data (cell_value),
		.rd_en   (accept),
		.rd_addr (col0),
		.rd_data (centre_rd)
	);

	nmss_ram #(.WIDTH(nmss_pkg::CELL_W), .DEPTH(MAX_DIM)) u_above_right (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (col0),
		.wr_data (cell_value),
		.rd_en   (accept),
		.rd_addr (right_addr),
		.rd_data (right_rd)
	);

	// row two above is filled from the centre read once it is known
	nmss_ram #(.WIDTH(nmss_pkg::CELL_W), .DEPTH(MAX_DIM)) u_two_above (
		.clk     (clk),
		.wr_en   (s1_adv),
		.wr_addr (col_s1),
		.wr_data (centre_rd),
		.rd_en   (accept),
		.rd_addr (col0),
		.rd_data (up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			win_q <= '0;
		end else begin
			if (s1_free) begin
				v_s1 <= cell_valid;
			end
			if (s2_ready) begin
				v_s2 <= v_s1;
			end
			if (s1_adv) begin
				win_q <= centre_rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1 <= cell_value;
			col_s1  <= col0;
			ctl_s1  <= ctl0;
		end
		if (s1_adv) begin
			umin_s2   <= umin;
			lmax_s2   <= lmax;
			centre_s2 <= centre_rd;
			cell_s2   <= cell_s1;
			ctl_s2    <= ctl_s1;
		end
	end

	nmss_sort u_sort (
		.east      (right_rd),
		.west      (win_q),
		.north     (up_rd),
		.south     (cell_s1),
		.upper_min (umin),
		.lower_max (lmax)
	);

	nmss_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (out_load),
		.ctl          (ctl_s2),
		.upper_min    (umin_s2),
		.lower_max    (lmax_s2),
		.centre       (centre_s2),
		.own_cell     (cell_s2),
		.modulus      (mod_q),
		.result_stall (result_stall),
		.take         (out_take),
		.result_valid (result_valid),
		.new_value    (new_value),
		.run_end      (run_end),
		.board_end    (board_end)
	);

endmodule

/* rtl/nmss_checker.sv */
// ---------------------------------------------------------------------------
// nmss_checker
// port-level checks on the stencil result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "neighbour_middle_sum_stencil_macros.svh"

module nmss_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        result_valid,
	input logic                        result_stall,
	input logic [nmss_pkg::CELL_W-1:0] new_value,
	input logic                        run_end,
	input logic                        board_end
);

	`ASSERT_NEXT(a_valid_holds, result_valid && result_stall, result_valid)
	`ASSERT_NEXT(a_payload_holds, result_valid && result_stall, $stable({new_value, run_end, board_end}))
	// the last cell of a board always closes its item
	`ASSERT_NOW(a_board_end_closes, result_valid && board_end, run_end)
	// the second result of a last-row item is already held
	`ASSERT_NEXT(a_pair_follows, result_valid && !result_stall && !run_end, result_valid)

endmodule

bind neighbour_middle_sum_stencil nmss_checker u_nmss_checker (.*);

/* verif/tb_neighbour_middle_sum_stencil.sv */
// ---------------------------------------------------------------------------
// tb_neighbour_middle_sum_stencil
// Streams square boards through the stencil and checks every next-board
// cell against an in-bench model of the line stores, the neighbour window
// and the wrapped middle-two sum. Covers the reset board size, out-of-range
// sizes, mid-board register writes, modulus extremes, random boards under
// random idling, and a long result hold-off that backs up the cell input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_neighbour_middle_sum_stencil;

	localparam int CELL_W    = nmss_pkg::CELL_W;
	localparam int SUM_W     = nmss_pkg::SUM_W;
	localparam int DIM_W     = nmss_pkg::DIM_W;
	localparam int MOD_W     = nmss_pkg::MOD_W;
	localparam int CFG_W     = nmss_pkg::CFG_W;
	localparam int CFG_IDX_W = nmss_pkg::CFG_IDX_W;
	localparam int MIN_DIM   = nmss_pkg::MIN_DIM;

	localparam int BOARD_MAX      = 4096;
	localparam int CELL_MAX       = (1 << CELL_W) - 1;
	localparam int WIDE_CELLS     = 64;
	localparam int RANDOM_CELLS   = 1110;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [CELL_W-1:0] CELL_FULL = CELL_W'(CELL_MAX);

	typedef struct packed {
		logic [CELL_W-1:0] value;
		logic              run_end;
		logic              board_end;
	} next_cell_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cell_valid   = 1'b0;
	logic                 cell_stall;
	logic [CELL_W-1:0]    cell_value   = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [CELL_W-1:0]    new_value;
	logic                 run_end;
	logic                 board_end;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;

	// model of the block
	logic [DIM_W-1:0]  dim_reg = DIM_W'(nmss_pkg::DIM_RESET);
	logic [MOD_W-1:0]  mod_reg = nmss_pkg::MOD_RESET;
	logic [CELL_W-1:0] above_row [BOARD_MAX];
	logic [CELL_W-1:0] two_above_row [BOARD_MAX];
	logic [CELL_W-1:0] win_centre = '0;
	int unsigned       col_pos = 0;
	int unsigned       row_pos = 0;
	next_cell_t        pending_cells [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned cells_sent    = 0;
	int unsigned fail_count    = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned hold_left     = 0;
	bit          hold_req      = 1'b0;

	neighbour_middle_sum_stencil #(
		.MAX_DIM(BOARD_MAX)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_value(cell_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.new_value(new_value),
		.run_end(run_end),
		.board_end(board_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [CELL_W-1:0] cell_min(input logic [CELL_W-1:0] a, b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [CELL_W-1:0] cell_max(input logic [CELL_W-1:0] a, b);
		return (a < b) ? b : a;
	endfunction

	function automatic logic [CELL_W-1:0] wrapped_middle_sum(
		input logic [CELL_W-1:0] east, west, north, south
	);
		logic [CELL_W-1:0] upper_min, lower_max;
		logic [SUM_W-1:0]  total;
		upper_min = cell_min(cell_max(east, west), cell_max(north, south));
		lower_max = cell_max(cell_min(east, west), cell_min(north, south));
		total = {1'b0, upper_min} + {1'b0, lower_max};
		// at most one subtraction, a zero modulus leaves the sum alone
		if (total >= mod_reg)
			total = total - mod_reg;
		return total[CELL_W-1:0];
	endfunction

	function automatic int unsigned board_side();
		int unsigned d;
		d = dim_reg;
		if (d < MIN_DIM)
			d = MIN_DIM;
		if (d > BOARD_MAX)
			d = BOARD_MAX;
		return d;
	endfunction

	// one accepted cell past the first row releases the cell above it, and in the last row itself too
	task automatic predict_cell(input logic [CELL_W-1:0] cur_cell);
		int unsigned       d, c, r;
		logic [CELL_W-1:0] centre, right, up, left;
		logic              last_col, last_row;
		d = board_side();
		c = (col_pos >= d) ? d - 1 : col_pos;
		r = row_pos;
		last_col = (c >= d - 1);
		last_row = (r >= d - 1);
		centre = above_row[c];
		right = (c + 1 < BOARD_MAX) ? above_row[c + 1] : '0;
		up = two_above_row[c];
		left = win_centre;
		win_centre = centre;
		if (r >= 1) begin
			if (r == 1 || c == 0 || last_col || r - 1 >= d - 1)
				pending_cells.push_back(next_cell_t'{centre, !last_row, 1'b0});
			else
				pending_cells.push_back(next_cell_t'{
					wrapped_middle_sum(right, left, up, cur_cell), !last_row, 1'b0});
		end
		if (last_row)
			pending_cells.push_back(next_cell_t'{cur_cell, 1'b1, last_col});
		two_above_row[c] = centre;
		above_row[c] = cur_cell;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	task automatic send_cell(input logic [CELL_W-1:0] value);
		if ($urandom_range(99) < send_idle_pct) begin
			cell_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cell_valid <= 1'b1;
		cell_value <= value;
		do @(posedge clk); while (cell_stall);
		cells_sent++;
		predict_cell(value);
	endtask

	task automatic write_reg(input nmss_pkg::cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == nmss_pkg::CFG_BOARD_DIM)
			dim_reg = data[DIM_W-1:0];
		else
			mod_reg = data[MOD_W-1:0];
		@(posedge clk);
	endtask

	// wait until every released cell is out and the pipeline is quiet
	task automatic settle();
		cell_valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CELL_W-1:0] random_cell();
		if (mod_reg != 0 && mod_reg <= CELL_MAX + 1 && $urandom_range(99) < 85)
			return CELL_W'($urandom_range(mod_reg - 1));
		return CELL_W'($urandom_range(CELL_MAX));
	endfunction

	function automatic logic [CFG_W-1:0] random_modulus();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return '0;
		if (pick < 16)
			return CFG_W'(CELL_MAX + 1);
		if (pick < 20)
			return {CFG_W{1'b1}};
		if (pick < 26)
			return CFG_W'(1);
		if (pick < 34)
			return CFG_W'($urandom_range(2, 64));
		return CFG_W'($urandom_range(2, CELL_MAX));
	endfunction

	function automatic logic [CFG_W-1:0] random_dim();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 3)
			return CFG_W'($urandom_range(0, MIN_DIM - 1));
		if (pick < 10)
			return CFG_W'($urandom_range(11, 24));
		return CFG_W'($urandom_range(MIN_DIM, 10));
	endfunction

	task automatic finish_board();
		do send_cell(random_cell()); while (col_pos != 0 || row_pos != 0);
	endtask

	// reset size: part of a first row at the widest board, then shrink mid-board
	task automatic test_widest_board();
		for (int i = 0; i < WIDE_CELLS; i++)
			send_cell(CELL_W'($urandom_range(CELL_MAX)));
		settle();
		write_reg(nmss_pkg::CFG_BOARD_DIM, CFG_W'(MIN_DIM));
		finish_board();
	endtask

	// oversized dimension acts as the widest, then a shrink past the column count
	task automatic test_dim_above_max();
		logic [CELL_W-1:0] cells [11];
		cells = '{CELL_FULL, CELL_FULL, '0, '0, CELL_FULL,
			'0, CELL_FULL, CELL_FULL,
			CELL_FULL, CELL_FULL, '0};
		settle();
		write_reg(nmss_pkg::CFG_BOARD_DIM, CFG_W'({DIM_W{1'b1}}));
		write_reg(nmss_pkg::CFG_VALUE_MODULUS, CFG_W'(CELL_MAX + 1));
		for (int i = 0; i < 11; i++) begin
			if (i == 4) begin
				settle();
				write_reg(nmss_pkg::CFG_BOARD_DIM, CFG_W'(MIN_DIM));
			end
			send_cell(cells[i]);
		end
	endtask

	// zero modulus keeps the raw sum, only its low bits come out
	task automatic test_zero_modulus();
		logic [CELL_W-1:0] cells [9];
		cells = '{'0, CELL_FULL, '0,
			CELL_W'(16384), CELL_W'(12345), '0,
			'0, CELL_FULL, '0};
		settle();
		write_reg(nmss_pkg::CFG_BOARD_DIM, '0);
		write_reg(nmss_pkg::CFG_VALUE_MODULUS, '0);
		for (int i = 0; i < 9; i++)
			send_cell(cells[i]);
	endtask

	task automatic test_dim_below_min();
		settle();
		write_reg(nmss_pkg::CFG_BOARD_DIM, CFG_W'(MIN_DIM - 1));
		write_reg(nmss_pkg::CFG_VALUE_MODULUS, CFG_W'(1));
		finish_board();
	endtask

	task automatic test_random_boards(input int unsigned n_cells);
		int unsigned stop_at, change_at, board_cells;
		stop_at = cells_sent + n_cells;
		while (cells_sent < stop_at) begin
			settle();
			if ($urandom_range(1))
				write_reg(nmss_pkg::CFG_VALUE_MODULUS, random_modulus());
			write_reg(nmss_pkg::CFG_BOARD_DIM, random_dim());
			change_at = 0;
			if ($urandom_range(4) == 0)
				change_at = $urandom_range(1, board_side() * board_side() - 1);
			board_cells = 0;
			do begin
				if (change_at != 0 && board_cells == change_at) begin
					settle();
					// shrinking never exposes an unwritten line store entry
					if (board_side() > MIN_DIM && $urandom_range(1))
						write_reg(nmss_pkg::CFG_BOARD_DIM,
							CFG_W'($urandom_range(0, board_side() - 1)));
					else
						write_reg(nmss_pkg::CFG_VALUE_MODULUS, random_modulus());
				end
				send_cell(random_cell());
				board_cells++;
			end while (col_pos != 0 || row_pos != 0);
		end
	endtask

	// results held off for a long stretch while cells keep coming
	task automatic test_result_backpressure();
		settle();
		write_reg(nmss_pkg::CFG_BOARD_DIM, CFG_W'(12));
		write_reg(nmss_pkg::CFG_VALUE_MODULUS, random_modulus());
		hold_req = 1'b1;
		finish_board();
	endtask

	always @(posedge clk) begin : receiver
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
		end else if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin : check_results
		next_cell_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_cells.size() == 0) begin
				$error("new_value: expected none, actual %0d", new_value);
				fail_count++;
			end else begin
				want = pending_cells.pop_front();
				if (new_value !== want.value) begin
					$error("new_value: expected %0d, actual %0d", want.value, new_value);
					fail_count++;
				end
				if (run_end !== want.run_end) begin
					$error("run_end: expected %0b, actual %0b", want.run_end, run_end);
					fail_count++;
				end
				if (board_end !== want.board_end) begin
					$error("board_end: expected %0b, actual %0b", want.board_end, board_end);
					fail_count++;
				end
			end
		end
	end

	// any transfer on any channel counts as progress
	always @(posedge clk) begin : watchdog
		if ((cell_valid && !cell_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : main
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 22;
		recv_idle_pct = 59;
		test_widest_board();
		test_dim_above_max();
		test_zero_modulus();
		test_dim_below_min();
		test_random_boards(RANDOM_CELLS / 3);

		send_idle_pct = 59;
		recv_idle_pct = 22;
		test_random_boards(RANDOM_CELLS / 3);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_boards(RANDOM_CELLS / 3);
		test_result_backpressure();

		settle();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* neighbour_middle_sum_stencil.f */
+incdir+rtl
rtl/nmss_pkg.sv
rtl/nmss_ram.sv
rtl/nmss_sort.sv
rtl/nmss_out.sv
rtl/neighbour_middle_sum_stencil.sv
rtl/nmss_checker.sv
verif/tb_neighbour_middle_sum_stencil.sv
